/* src/rpr_pkg.sv */
`default_nettype none
package rpr_pkg;

	localparam int MAX_FRAME      = 256;
	localparam int CHECKSUM_BYTES = 2;
	localparam int CNT_W          = $clog2(MAX_FRAME + 1);

	localparam int BYTE_W     = 8;
	localparam int TS_W       = 40;
	localparam int START_W    = 32;
	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam int REPLY_BYTES  = 22;
	localparam int IDX_W        = $clog2(REPLY_BYTES);
	localparam int REPLY_LENGTH = 24;

	localparam logic [BYTE_W-1:0] FC_LO  = 8'h41;
	localparam logic [BYTE_W-1:0] FC_HI  = 8'h88;
	localparam logic [BYTE_W-1:0] CHAR_P = 8'h50;
	localparam logic [BYTE_W-1:0] CHAR_I = 8'h49;
	localparam logic [BYTE_W-1:0] CHAR_O = 8'h4F;

	localparam logic [ADDR_W-1:0] PAN_RESET  = 16'hCAFE;
	localparam logic [ADDR_W-1:0] DEST_RESET = 16'h1234;
	localparam logic [ADDR_W-1:0] SRC_RESET  = 16'h5678;
	localparam logic [TS_W-1:0]   DELAY_RESET = TS_W'(64'd12000 * 64'd65536);

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE  = 2'd0,
		CMD_END   = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAN_ID      = 2'd0,
		REG_DEST_ADDR   = 2'd1,
		REG_SRC_ADDR    = 2'd2,
		REG_REPLY_DELAY = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pan_id;
		logic [ADDR_W-1:0] dest_address;
		logic [ADDR_W-1:0] source_address;
		logic [TS_W-1:0]   reply_delay;
	} rpr_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  seq;
		logic [BYTE_W-1:0]  mac;
		logic [TS_W-1:0]    t2;
		logic [START_W-1:0] start;
	} rpr_reply_t;

	typedef struct packed {
		logic       valid;
		rpr_reply_t data;
	} rpr_reply_req_t;

endpackage
`default_nettype wire

/* src/rpr_in_if.sv */
`default_nettype none
interface rpr_in_if;
	logic                           valid;
	logic                           ready;
	logic [rpr_pkg::CMD_W-1:0]      command;
	logic [rpr_pkg::BYTE_W-1:0]     rx_byte;
	logic [rpr_pkg::TS_W-1:0]       rx_timestamp;

	modport source (output valid, output command, output rx_byte, output rx_timestamp,
		input ready);
	modport sink (input valid, input command, input rx_byte, input rx_timestamp,
		output ready);
endinterface
`default_nettype wire

/* src/rpr_out_if.sv */
`default_nettype none
interface rpr_out_if;
	logic                           valid;
	logic                           ready;
	logic [rpr_pkg::BYTE_W-1:0]     tx_byte;
	logic                           tx_last;
	logic [rpr_pkg::START_W-1:0]    tx_start_time;
	logic [rpr_pkg::BYTE_W-1:0]     tx_length;

	modport source (output valid, output tx_byte, output tx_last, output tx_start_time,
		output tx_length, input ready);
	modport sink (input valid, input tx_byte, input tx_last, input tx_start_time,
		input tx_length, output ready);
endinterface
`default_nettype wire

/* src/rpr_parser.sv */
`default_nettype none
module rpr_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rpr_in_if.sink                 in_ch,
	input  wire rpr_pkg::rpr_cfg_t cfg,
	input  wire logic              busy,
	output rpr_pkg::rpr_reply_req_t req
);
	import rpr_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] prev_q;
	logic              pair_q;
	logic              match_q;
	logic [BYTE_W-1:0] seq_q;
	logic [CNT_W-1:0]  seq_pos_q;
	logic [BYTE_W-1:0] mac_q;

	logic              accept;
	cmd_t              cmd;
	logic              have_room;
	logic              reply_ok;
	logic [TS_W-1:0]   sum;

	assign in_ch.ready = !busy;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cmd         = cmd_t'(in_ch.command);
	assign have_room   = count_q < CNT_W'(MAX_FRAME);
	assign reply_ok    = (count_q > CNT_W'(CHECKSUM_BYTES)) && match_q &&
		(seq_pos_q < (count_q - CNT_W'(CHECKSUM_BYTES)));
	assign sum         = in_ch.rx_timestamp + cfg.reply_delay;

	assign req.valid      = accept && (cmd == CMD_END) && reply_ok;
	assign req.data.seq   = seq_q;
	assign req.data.mac   = mac_q;
	assign req.data.t2    = in_ch.rx_timestamp;
	assign req.data.start = sum[TS_W-1:TS_W-START_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			prev_q    <= '0;
			pair_q    <= 1'b0;
			match_q   <= 1'b0;
			seq_q     <= '0;
			seq_pos_q <= '0;
			mac_q     <= '0;
		end else if (accept) begin
			unique case (cmd)
				CMD_BYTE: begin
					if (have_room) begin
						if (!pair_q && (count_q != '0) && (prev_q == CHAR_P) &&
							(in_ch.rx_byte == CHAR_I)) begin
							pair_q    <= 1'b1;
							seq_pos_q <= count_q + CNT_W'(1);
						end else if (pair_q && !match_q && (count_q == seq_pos_q)) begin
							seq_q   <= in_ch.rx_byte;
							match_q <= 1'b1;
						end
						prev_q  <= in_ch.rx_byte;
						count_q <= count_q + CNT_W'(1);
					end
				end
				CMD_END, CMD_ERROR: begin
					if ((cmd == CMD_END) && reply_ok) begin
						mac_q <= mac_q + BYTE_W'(1);
					end
					count_q   <= '0;
					prev_q    <= '0;
					pair_q    <= 1'b0;
					match_q   <= 1'b0;
					seq_q     <= '0;
					seq_pos_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	a_match_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		match_q |-> pair_q) else $error("sequence byte captured without a pair");
	a_seq_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_q |-> (seq_pos_q <= count_q)) else $error("sequence position ahead of count");
	a_no_req_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !busy) else $error("reply issued while pending slot full");

endmodule
`default_nettype wire

/* src/rpr_serializer.sv */
`default_nettype none
module rpr_serializer (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rpr_pkg::rpr_reply_req_t req,
	input  wire rpr_pkg::rpr_cfg_t       cfg,
	output logic                         busy,
	rpr_out_if.source                    out_ch
);
	import rpr_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_BYTES - 1);

	logic                          pend_valid_q;
	rpr_reply_t                    pend_q;
	logic                          active_q;
	logic [IDX_W-1:0]              idx_q;
	rpr_reply_t                    cur_q;
	logic                          out_valid_q;
	logic [BYTE_W-1:0]             byte_q;
	logic                          last_q;
	logic [START_W-1:0]            start_q;

	logic                          load;
	logic                          at_last;
	logic                          take;
	logic [TS_W-1:0]               t3;
	logic [REPLY_BYTES-1:0][BYTE_W-1:0] frame;

	assign busy    = pend_valid_q;
	assign load    = active_q && (!out_valid_q || out_ch.ready);
	assign at_last = idx_q == LAST_IDX;
	assign take    = pend_valid_q && (!active_q || (load && at_last));
	assign t3      = {cur_q.start, 8'h00};

	always_comb begin
		frame[0]  = FC_LO;
		frame[1]  = FC_HI;
		frame[2]  = cur_q.mac;
		frame[3]  = cfg.pan_id[7:0];
		frame[4]  = cfg.pan_id[15:8];
		frame[5]  = cfg.dest_address[7:0];
		frame[6]  = cfg.dest_address[15:8];
		frame[7]  = cfg.source_address[7:0];
		frame[8]  = cfg.source_address[15:8];
		frame[9]  = CHAR_P;
		frame[10] = CHAR_O;
		frame[11] = cur_q.seq;
		for (int k = 0; k < 5; k++) begin
			frame[12 + k] = cur_q.t2[8*k +: 8];
			frame[17 + k] = t3[8*k +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			active_q     <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (req.valid) begin
				pend_valid_q <= 1'b1;
			end else if (take) begin
				pend_valid_q <= 1'b0;
			end
			if (take) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load && at_last) begin
				active_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			pend_q <= req.data;
		end
		if (take) begin
			cur_q <= pend_q;
		end
		if (load) begin
			byte_q  <= frame[idx_q];
			last_q  <= at_last;
			start_q <= cur_q.start;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.tx_byte       = byte_q;
	assign out_ch.tx_last       = last_q;
	assign out_ch.tx_start_time = start_q;
	assign out_ch.tx_length     = BYTE_W'(REPLY_LENGTH);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !pend_valid_q) else $error("pending reply overwritten");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= LAST_IDX)) else $error("byte index out of range");
	a_end_of_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(load && at_last && !pend_valid_q) |=> (!active_q && out_valid_q && last_q))
		else $error("reply did not close on last byte");

endmodule
`default_nettype wire

/* src/ranging_ping_responder.sv */
// Ranging ping responder, responder side of two-way ranging.
// in_ch carries one item per transfer: command 0 with a received frame byte,
// command 1 for a good frame end with its 40-bit receive timestamp, command 2
// for a receive error or timeout. Command 3 is dropped.
// out_ch carries the 22-byte reply, one byte per transfer, tx_last on the
// final byte, with the delayed start time and length on every byte.
// Configuration: cfg_we, cfg_index and cfg_data write pan_id (0),
// dest_address (1), source_address (2) and reply_delay (3) registers;
// write only while no reply is in flight.
// Throughput: in_ch takes one item per cycle while ready is high. A matching frame end puts a
// reply into a one-entry pending slot; in_ch ready drops while that slot is
// full: in the cycle after each matching frame end, and beyond it while the
// serializer is still sending an earlier reply.
// The reply to a matching frame end goes from the pending slot to the
// current-reply register, then byte by byte into the single output byte
// register; bytes follow one per cycle while out_ch is ready.
// Reset clears the frame state and MAC sequence counter and reloads the
// register defaults. A stalled out_ch holds its byte and the serializer.
`default_nettype none
module ranging_ping_responder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	rpr_in_if.sink                               in_ch,
	rpr_out_if.source                            out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rpr_pkg::*;

	rpr_cfg_t       cfg_q;
	rpr_reply_req_t req;
	logic           busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_id         <= PAN_RESET;
			cfg_q.dest_address   <= DEST_RESET;
			cfg_q.source_address <= SRC_RESET;
			cfg_q.reply_delay    <= DELAY_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAN_ID:      cfg_q.pan_id         <= cfg_data[ADDR_W-1:0];
				REG_DEST_ADDR:   cfg_q.dest_address   <= cfg_data[ADDR_W-1:0];
				REG_SRC_ADDR:    cfg_q.source_address <= cfg_data[ADDR_W-1:0];
				REG_REPLY_DELAY: cfg_q.reply_delay    <= cfg_data[TS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.busy   (busy),
		.req    (req)
	);

	rpr_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg_q),
		.busy   (busy),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire
